FILE: hw/rtl/c_tok_pkg.sv
// shared types, constants and character tables for the c subset tokenizer
package c_tok_pkg;

    // sizing
    localparam int IDENT_MAX  = 31;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (IDENT_MAX > 1) ? $clog2(IDENT_MAX) : 1;
    localparam int LEN_W      = $clog2(IDENT_MAX + 1);
    localparam int NUM_W      = 32;
    localparam int LINE_W     = 16;
    localparam int QDEPTH     = 2;   // power of two
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int KW_COUNT   = 6;
    localparam int KW_SLOTS   = 6;

    typedef logic [4:0]            kind_t;
    typedef logic [VALUE_BITS-1:0] val_t;
    typedef logic [NUM_W-1:0]      num_t;
    typedef logic [LINE_W-1:0]     line_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [QPTR_W-1:0]     qptr_t;
    typedef logic [QCNT_W-1:0]     qcnt_t;
    typedef logic [2:0]            kw_idx_t;
    typedef logic [2:0]            slot_t;

    localparam line_t LINE_TOP = '1;

    // result kinds
    localparam kind_t KIND_EOF     = 5'd0;
    localparam kind_t KIND_INTLIT  = 5'd1;
    localparam kind_t KIND_IDENT   = 5'd2;
    localparam kind_t KIND_LPAREN  = 5'd3;
    localparam kind_t KIND_RPAREN  = 5'd4;
    localparam kind_t KIND_LBRACE  = 5'd5;
    localparam kind_t KIND_RBRACE  = 5'd6;
    localparam kind_t KIND_LBRACK  = 5'd7;
    localparam kind_t KIND_RBRACK  = 5'd8;
    localparam kind_t KIND_SEMI    = 5'd9;
    localparam kind_t KIND_COLON   = 5'd10;
    localparam kind_t KIND_COMMA   = 5'd11;
    localparam kind_t KIND_DOT     = 5'd12;
    localparam kind_t KIND_PLUS    = 5'd13;
    localparam kind_t KIND_MINUS   = 5'd14;
    localparam kind_t KIND_STAR    = 5'd15;
    localparam kind_t KIND_SLASH   = 5'd16;
    localparam kind_t KIND_ASSIGN  = 5'd17;
    localparam kind_t KIND_KW_INT  = 5'd18;
    localparam kind_t KIND_KW_CHAR = 5'd19;
    localparam kind_t KIND_KW_IF   = 5'd20;
    localparam kind_t KIND_KW_ELSE = 5'd21;
    localparam kind_t KIND_KW_WHILE  = 5'd22;
    localparam kind_t KIND_KW_RETURN = 5'd23;
    localparam kind_t KIND_INVALID = 5'd24;

    // lexer mode
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_DEAD
    } mode_t;

    // back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_A_OUT,
        BK_RUN_RD,
        BK_RUN_WR,
        BK_B_OUT
    } back_state_t;

    // work handed from front to back: an optional flushed token, then an
    // optional single result (punctuation, invalid or eof)
    typedef struct packed {
        logic  a_valid;
        logic  a_run;
        kind_t a_kind;
        val_t  a_num;
        len_t  a_len;
        logic  b_valid;
        kind_t b_kind;
        line_t line;
    } tok_op_t;

    // keyword spellings, zero padded
    localparam logic [7:0] KW_CHARS [KW_COUNT][KW_SLOTS] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"r", "e", "t", "u", "r", "n"}
    };
    localparam int    KW_LENS  [KW_COUNT] = '{3, 4, 2, 4, 5, 6};
    localparam kind_t KW_KINDS [KW_COUNT] = '{KIND_KW_INT, KIND_KW_CHAR, KIND_KW_IF,
                                              KIND_KW_ELSE, KIND_KW_WHILE,
                                              KIND_KW_RETURN};

    function automatic logic [7:0] kw_char(input kw_idx_t k, input len_t pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (int'(pos) < KW_SLOTS)
        begin
            ch = KW_CHARS[k][slot_t'(pos)];
        end
        return ch;
    endfunction

    // punctuation code, zero when not punctuation
    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "[":     k = KIND_LBRACK;
            "]":     k = KIND_RBRACK;
            ";":     k = KIND_SEMI;
            ":":     k = KIND_COLON;
            ",":     k = KIND_COMMA;
            ".":     k = KIND_DOT;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "=":     k = KIND_ASSIGN;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/c_subset_tokenizer_top.sv
// top level of the c subset tokenizer: front end, work queue, back end, name buffer
// path: input beats pass the work queue, the back end work item and the output register
// throughput: one source beat per cycle while the 2-entry work queue has room and no
// identifier run is pending; the back end takes each queued item in idle, outputs each result
// in turn and reads each run char before outputting it; input is held until the last read
// reset: rst_n clears lexer mode, counters, queue and output valid; line number restarts at 1
module c_subset_tokenizer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 cmd,
    input  logic [7:0]           char_in,
    output logic                 empty,
    input  logic                 pop,
    output logic [4:0]           kind,
    output logic [31:0]          number,
    output logic [7:0]           text_char,
    output logic [15:0]          line_no,
    output logic                 last
);

    logic                 q_wr;
    c_tok_pkg::tok_op_t   q_wr_data;
    logic                 q_full;
    logic                 q_rd;
    c_tok_pkg::tok_op_t   q_rd_data;
    logic                 q_empty;
    logic                 run_done;
    logic                 buf_wr_en;
    c_tok_pkg::idx_t      buf_wr_addr;
    logic [7:0]           buf_wr_data;
    logic                 buf_rd_en;
    c_tok_pkg::idx_t      buf_rd_addr;
    logic [7:0]           buf_rd_data;

    // lexer front end
    c_tok_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .char_in     (char_in),
        .q_wr        (q_wr),
        .q_data      (q_wr_data),
        .q_full      (q_full),
        .run_done    (run_done),
        .buf_wr_en   (buf_wr_en),
        .buf_wr_addr (buf_wr_addr),
        .buf_wr_data (buf_wr_data)
    );

    // token work queue
    c_tok_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    // identifier name buffer
    c_tok_ram #(
        .WIDTH (8),
        .DEPTH (c_tok_pkg::IDENT_MAX)
    ) u_name_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_en   (buf_rd_en),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    // result back end
    c_tok_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rd_data),
        .q_rd        (q_rd),
        .buf_rd_en   (buf_rd_en),
        .buf_rd_addr (buf_rd_addr),
        .buf_rd_data (buf_rd_data),
        .run_done    (run_done),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .number      (number),
        .text_char   (text_char),
        .line_no     (line_no),
        .last        (last)
    );

endmodule

FILE: hw/rtl/c_tok_ram.sv
// generic single write port ram with registered read
module c_tok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/c_tok_fifo.sv
// small register queue between front and back
module c_tok_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  c_tok_pkg::tok_op_t wr_data,
    output logic               q_full,
    input  logic               rd_en,
    output c_tok_pkg::tok_op_t rd_data,
    output logic               q_empty
);

    c_tok_pkg::tok_op_t entries [c_tok_pkg::QDEPTH];
    c_tok_pkg::qptr_t   wr_ptr_reg;
    c_tok_pkg::qptr_t   wr_ptr_next;
    c_tok_pkg::qptr_t   rd_ptr_reg;
    c_tok_pkg::qptr_t   rd_ptr_next;
    c_tok_pkg::qcnt_t   count_reg;
    c_tok_pkg::qcnt_t   count_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == c_tok_pkg::qcnt_t'(c_tok_pkg::QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entries[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + c_tok_pkg::qptr_t'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + c_tok_pkg::qptr_t'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + c_tok_pkg::qcnt_t'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - c_tok_pkg::qcnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/c_tok_front.sv
// front end: accepts source beats, tracks lexer state, queues token work
module c_tok_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 cmd,
    input  logic [7:0]           char_in,
    output logic                 q_wr,
    output c_tok_pkg::tok_op_t   q_data,
    input  logic                 q_full,
    input  logic                 run_done,
    output logic                 buf_wr_en,
    output c_tok_pkg::idx_t      buf_wr_addr,
    output logic [7:0]           buf_wr_data
);

    c_tok_pkg::mode_t             mode_reg;
    c_tok_pkg::mode_t             mode_next;
    c_tok_pkg::len_t              len_reg;
    c_tok_pkg::len_t              len_next;
    c_tok_pkg::val_t              accum_reg;
    c_tok_pkg::val_t              accum_next;
    c_tok_pkg::line_t             line_reg;
    c_tok_pkg::line_t             line_next;
    logic [c_tok_pkg::KW_COUNT-1:0] match_reg;
    logic [c_tok_pkg::KW_COUNT-1:0] match_next;
    logic                         run_pend_reg;
    logic                         run_pend_next;

    logic                         accept;
    logic                         is_alpha;
    logic                         is_digit;
    logic                         is_space;
    logic                         is_nl;
    c_tok_pkg::kind_t             pkind;
    logic                         kw_hit;
    c_tok_pkg::kind_t             kw_kind;
    c_tok_pkg::val_t              digit_val;
    c_tok_pkg::tok_op_t           op;

    // input stalls while the queue is full or an identifier run still reads the buffer
    assign full   = q_full || run_pend_reg;
    assign accept = push && !full;

    // character classes
    assign is_alpha  = char_in inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f};
    assign is_digit  = char_in inside {[8'h30:8'h39]};
    assign is_space  = char_in inside {8'h20, 8'h09, 8'h0b, 8'h0d, 8'h0c};
    assign is_nl     = (char_in == 8'h0a);
    assign pkind     = c_tok_pkg::punct_kind(char_in);
    assign digit_val = c_tok_pkg::val_t'(char_in[3:0]);

    // keyword hit from the running per-keyword match flags
    always_comb
    begin
        kw_hit  = 1'b0;
        kw_kind = c_tok_pkg::KIND_EOF;
        for (int k = 0; k < c_tok_pkg::KW_COUNT; k++)
        begin
            if (match_reg[k] && (int'(len_reg) == c_tok_pkg::KW_LENS[k]))
            begin
                kw_hit  = 1'b1;
                kw_kind = kw_kind | c_tok_pkg::KW_KINDS[k];
            end
        end
    end

    // lexer step
    always_comb
    begin
        mode_next   = mode_reg;
        len_next    = len_reg;
        accum_next  = accum_reg;
        line_next   = line_reg;
        match_next  = match_reg;
        op          = '0;
        op.line     = line_reg;
        buf_wr_en   = 1'b0;
        buf_wr_addr = c_tok_pkg::idx_t'(len_reg);
        buf_wr_data = char_in;
        if (accept && (mode_reg != c_tok_pkg::MODE_DEAD))
        begin
            if (!cmd && (mode_reg == c_tok_pkg::MODE_IDENT) && (is_alpha || is_digit))
            begin
                // extend identifier, drop characters past the limit
                if (len_reg < c_tok_pkg::len_t'(c_tok_pkg::IDENT_MAX))
                begin
                    buf_wr_en = 1'b1;
                    len_next  = len_reg + c_tok_pkg::len_t'(1);
                    for (int k = 0; k < c_tok_pkg::KW_COUNT; k++)
                    begin
                        match_next[k] = match_reg[k] &&
                            (char_in == c_tok_pkg::kw_char(c_tok_pkg::kw_idx_t'(k), len_reg));
                    end
                end
            end
            else if (!cmd && (mode_reg == c_tok_pkg::MODE_NUM) && is_digit)
            begin
                // accum * 10 + digit
                accum_next = (accum_reg << 3) + (accum_reg << 1) + digit_val;
            end
            else
            begin
                // flush pending token
                if (mode_reg == c_tok_pkg::MODE_IDENT)
                begin
                    op.a_valid = 1'b1;
                    if (kw_hit)
                    begin
                        op.a_kind = kw_kind;
                    end
                    else
                    begin
                        op.a_run  = 1'b1;
                        op.a_kind = c_tok_pkg::KIND_IDENT;
                        op.a_len  = len_reg;
                    end
                end
                else if (mode_reg == c_tok_pkg::MODE_NUM)
                begin
                    op.a_valid = 1'b1;
                    op.a_kind  = c_tok_pkg::KIND_INTLIT;
                    op.a_num   = accum_reg;
                end
                mode_next  = c_tok_pkg::MODE_IDLE;
                len_next   = '0;
                accum_next = '0;

                // end of input, blank, newline or start of the next token
                if (cmd)
                begin
                    op.b_valid = 1'b1;
                    op.b_kind  = c_tok_pkg::KIND_EOF;
                end
                else if (is_space)
                begin
                    mode_next = c_tok_pkg::MODE_IDLE;
                end
                else if (is_nl)
                begin
                    if (line_reg != c_tok_pkg::LINE_TOP)
                    begin
                        line_next = line_reg + c_tok_pkg::line_t'(1);
                    end
                end
                else if (is_alpha)
                begin
                    mode_next   = c_tok_pkg::MODE_IDENT;
                    buf_wr_en   = 1'b1;
                    buf_wr_addr = '0;
                    len_next    = c_tok_pkg::len_t'(1);
                    for (int k = 0; k < c_tok_pkg::KW_COUNT; k++)
                    begin
                        match_next[k] =
                            (char_in == c_tok_pkg::kw_char(c_tok_pkg::kw_idx_t'(k), '0));
                    end
                end
                else if (is_digit)
                begin
                    mode_next  = c_tok_pkg::MODE_NUM;
                    accum_next = digit_val;
                end
                else if (pkind != c_tok_pkg::KIND_EOF)
                begin
                    op.b_valid = 1'b1;
                    op.b_kind  = pkind;
                end
                else
                begin
                    op.b_valid = 1'b1;
                    op.b_kind  = c_tok_pkg::KIND_INVALID;
                    mode_next  = c_tok_pkg::MODE_DEAD;
                end
            end
        end
    end

    assign q_wr   = accept && (op.a_valid || op.b_valid);
    assign q_data = op;

    // pending identifier run tracking
    always_comb
    begin
        run_pend_next = run_pend_reg;
        if (q_wr && op.a_run)
        begin
            run_pend_next = 1'b1;
        end
        else if (run_done)
        begin
            run_pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= c_tok_pkg::MODE_IDLE;
            len_reg      <= '0;
            accum_reg    <= '0;
            line_reg     <= c_tok_pkg::line_t'(1);
            match_reg    <= '0;
            run_pend_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            len_reg      <= len_next;
            accum_reg    <= accum_next;
            line_reg     <= line_next;
            match_reg    <= match_next;
            run_pend_reg <= run_pend_next;
        end
    end

endmodule

FILE: hw/rtl/c_tok_back.sv
// back end: turns queued token work into result beats
module c_tok_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  c_tok_pkg::tok_op_t   q_data,
    output logic                 q_rd,
    output logic                 buf_rd_en,
    output c_tok_pkg::idx_t      buf_rd_addr,
    input  logic [7:0]           buf_rd_data,
    output logic                 run_done,
    output logic                 empty,
    input  logic                 pop,
    output c_tok_pkg::kind_t     kind,
    output c_tok_pkg::num_t      number,
    output logic [7:0]           text_char,
    output c_tok_pkg::line_t     line_no,
    output logic                 last
);

    c_tok_pkg::back_state_t state_reg;
    c_tok_pkg::back_state_t state_next;
    c_tok_pkg::tok_op_t     cur_reg;
    c_tok_pkg::idx_t        idx_reg;
    c_tok_pkg::idx_t        idx_next;
    logic                   valid_reg;
    logic                   valid_next;
    c_tok_pkg::kind_t       kind_reg;
    c_tok_pkg::num_t        number_reg;
    logic [7:0]             text_reg;
    c_tok_pkg::line_t       line_reg;
    logic                   last_reg;

    logic                   out_free;
    logic                   run_last;
    logic                   ld;
    c_tok_pkg::kind_t       ld_kind;
    c_tok_pkg::num_t        ld_number;
    logic [7:0]             ld_text;
    logic                   ld_last;

    assign out_free = !valid_reg || pop;
    assign run_last = (c_tok_pkg::len_t'(idx_reg) + c_tok_pkg::len_t'(1)) == cur_reg.a_len;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            c_tok_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_data.a_valid && q_data.a_run)
                    begin
                        state_next = c_tok_pkg::BK_RUN_RD;
                    end
                    else if (q_data.a_valid)
                    begin
                        state_next = c_tok_pkg::BK_A_OUT;
                    end
                    else
                    begin
                        state_next = c_tok_pkg::BK_B_OUT;
                    end
                end
            end
            c_tok_pkg::BK_A_OUT:
            begin
                if (out_free)
                begin
                    state_next = cur_reg.b_valid ? c_tok_pkg::BK_B_OUT : c_tok_pkg::BK_IDLE;
                end
            end
            c_tok_pkg::BK_RUN_RD:
            begin
                state_next = c_tok_pkg::BK_RUN_WR;
            end
            c_tok_pkg::BK_RUN_WR:
            begin
                if (out_free)
                begin
                    if (!run_last)
                    begin
                        state_next = c_tok_pkg::BK_RUN_RD;
                    end
                    else if (cur_reg.b_valid)
                    begin
                        state_next = c_tok_pkg::BK_B_OUT;
                    end
                    else
                    begin
                        state_next = c_tok_pkg::BK_IDLE;
                    end
                end
            end
            c_tok_pkg::BK_B_OUT:
            begin
                if (out_free)
                begin
                    state_next = c_tok_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = c_tok_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_rd        = 1'b0;
        buf_rd_en   = 1'b0;
        buf_rd_addr = idx_reg;
        run_done    = 1'b0;
        idx_next    = idx_reg;
        ld          = 1'b0;
        ld_kind     = cur_reg.a_kind;
        ld_number   = '0;
        ld_text     = 8'h00;
        ld_last     = 1'b1;
        case (state_reg)
            c_tok_pkg::BK_IDLE:
            begin
                q_rd     = !q_empty;
                idx_next = '0;
            end
            c_tok_pkg::BK_A_OUT:
            begin
                ld        = out_free;
                ld_number = c_tok_pkg::num_t'(cur_reg.a_num);
            end
            c_tok_pkg::BK_RUN_RD:
            begin
                buf_rd_en = 1'b1;
                run_done  = run_last;
            end
            c_tok_pkg::BK_RUN_WR:
            begin
                ld      = out_free;
                ld_kind = c_tok_pkg::KIND_IDENT;
                ld_text = buf_rd_data;
                ld_last = run_last;
                if (out_free)
                begin
                    idx_next = idx_reg + c_tok_pkg::idx_t'(1);
                end
            end
            c_tok_pkg::BK_B_OUT:
            begin
                ld      = out_free;
                ld_kind = cur_reg.b_kind;
            end
            default:
            begin
                ld = 1'b0;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        valid_next = valid_reg;
        if (ld)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c_tok_pkg::BK_IDLE;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // current work item and result payload
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            cur_reg <= q_data;
        end
        if (ld)
        begin
            kind_reg   <= ld_kind;
            number_reg <= ld_number;
            text_reg   <= ld_text;
            line_reg   <= cur_reg.line;
            last_reg   <= ld_last;
        end
    end

    assign empty     = !valid_reg;
    assign kind      = kind_reg;
    assign number    = number_reg;
    assign text_char = text_reg;
    assign line_no   = line_reg;
    assign last      = last_reg;

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the c subset tokenizer
`timescale 1ns / 1ps

module tb;

    // one expected result beat
    typedef struct packed {
        c_tok_pkg::kind_t kind;
        c_tok_pkg::num_t  number;
        logic [7:0]       text_char;
        c_tok_pkg::line_t line_no;
        logic             is_last;
    } token_beat_t;

    // one source beat waiting to be sent
    typedef struct {
        logic       eoi;
        logic [7:0] ch;
        int         gap;
        bit         drain;
    } src_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        cmd = 1'b0;
    logic [7:0]  char_in = 8'h00;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [4:0]  kind;
    logic [31:0] number;
    logic [7:0]  text_char;
    logic [15:0] line_no;
    logic        last;

    src_beat_t   src_beats [$];
    token_beat_t expected_tokens [$];
    int          fail_count = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          gap_left = 0;
    int          pop_wait = 0;
    int          rx_draw;
    bit          go;
    src_beat_t   nxt;
    token_beat_t want;

    // lexer state mirrored by the predictor
    c_tok_pkg::mode_t lex_mode = c_tok_pkg::MODE_IDLE;
    logic [7:0]       name_buf [c_tok_pkg::IDENT_MAX];
    int               name_len = 0;
    c_tok_pkg::num_t  lit_acc = '0;
    c_tok_pkg::line_t line_cnt = 16'd1;

    c_subset_tokenizer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .char_in   (char_in),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .number    (number),
        .text_char (text_char),
        .line_no   (line_no),
        .last      (last)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // character classes
    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // queue one expected beat at the current line
    function automatic void emit(input c_tok_pkg::kind_t k, input c_tok_pkg::num_t v,
                                 input logic [7:0] tc, input logic lst);
        token_beat_t b;
        b.kind      = k;
        b.number    = v;
        b.text_char = tc;
        b.line_no   = line_cnt;
        b.is_last   = lst;
        expected_tokens.push_back(b);
    endfunction

    // emit the pending name or literal and go back to idle
    function automatic void flush_token();
        logic [47:0]      spell;
        c_tok_pkg::kind_t kw;
        spell = '0;
        kw    = c_tok_pkg::KIND_IDENT;
        if (lex_mode == c_tok_pkg::MODE_IDENT)
        begin
            // keyword match on the kept text, names never hold a zero byte
            if (name_len <= 6)
            begin
                for (int i = 0; i < name_len; i++)
                    spell = {spell[39:0], name_buf[i]};
                case (spell)
                    {24'd0, "int"}:  kw = c_tok_pkg::KIND_KW_INT;
                    {16'd0, "char"}: kw = c_tok_pkg::KIND_KW_CHAR;
                    {32'd0, "if"}:   kw = c_tok_pkg::KIND_KW_IF;
                    {16'd0, "else"}: kw = c_tok_pkg::KIND_KW_ELSE;
                    {8'd0, "while"}: kw = c_tok_pkg::KIND_KW_WHILE;
                    "return":        kw = c_tok_pkg::KIND_KW_RETURN;
                    default:         kw = c_tok_pkg::KIND_IDENT;
                endcase
            end
            if (kw != c_tok_pkg::KIND_IDENT)
                emit(kw, '0, 8'h00, 1'b1);
            else
                for (int i = 0; i < name_len; i++)
                    emit(c_tok_pkg::KIND_IDENT, '0, name_buf[i], i == name_len - 1);
        end
        else if (lex_mode == c_tok_pkg::MODE_NUM)
        begin
            emit(c_tok_pkg::KIND_INTLIT, lit_acc, 8'h00, 1'b1);
        end
        lex_mode = c_tok_pkg::MODE_IDLE;
        name_len = 0;
        lit_acc  = '0;
    endfunction

    // predict the beats caused by one accepted source beat
    function automatic void lex_step(input logic eoi, input logic [7:0] c);
        c_tok_pkg::kind_t pk;
        pk = c_tok_pkg::KIND_INVALID;
        if (lex_mode != c_tok_pkg::MODE_DEAD)
        begin
            if (eoi)
            begin
                flush_token();
                emit(c_tok_pkg::KIND_EOF, '0, 8'h00, 1'b1);
            end
            else if (lex_mode == c_tok_pkg::MODE_IDENT && (is_alpha(c) || is_digit(c)))
            begin
                // characters past the name limit are dropped
                if (name_len < c_tok_pkg::IDENT_MAX)
                begin
                    name_buf[name_len] = c;
                    name_len++;
                end
            end
            else if (lex_mode == c_tok_pkg::MODE_NUM && is_digit(c))
            begin
                lit_acc = lit_acc * 32'd10 + c_tok_pkg::num_t'(c - 8'h30);
            end
            else
            begin
                // pending token goes out before the ending char is handled
                flush_token();
                case (c)
                    8'h09, 8'h0b, 8'h0c, 8'h0d, 8'h20: ;
                    8'h0a:
                    begin
                        if (line_cnt != c_tok_pkg::LINE_TOP)
                            line_cnt = line_cnt + 16'd1;
                    end
                    default:
                    begin
                        if (is_alpha(c))
                        begin
                            lex_mode    = c_tok_pkg::MODE_IDENT;
                            name_buf[0] = c;
                            name_len    = 1;
                        end
                        else if (is_digit(c))
                        begin
                            lex_mode = c_tok_pkg::MODE_NUM;
                            lit_acc  = c_tok_pkg::num_t'(c - 8'h30);
                        end
                        else
                        begin
                            case (c)
                                "(":     pk = c_tok_pkg::KIND_LPAREN;
                                ")":     pk = c_tok_pkg::KIND_RPAREN;
                                "{":     pk = c_tok_pkg::KIND_LBRACE;
                                "}":     pk = c_tok_pkg::KIND_RBRACE;
                                "[":     pk = c_tok_pkg::KIND_LBRACK;
                                "]":     pk = c_tok_pkg::KIND_RBRACK;
                                ";":     pk = c_tok_pkg::KIND_SEMI;
                                ":":     pk = c_tok_pkg::KIND_COLON;
                                ",":     pk = c_tok_pkg::KIND_COMMA;
                                ".":     pk = c_tok_pkg::KIND_DOT;
                                "+":     pk = c_tok_pkg::KIND_PLUS;
                                "-":     pk = c_tok_pkg::KIND_MINUS;
                                "*":     pk = c_tok_pkg::KIND_STAR;
                                "/":     pk = c_tok_pkg::KIND_SLASH;
                                "=":     pk = c_tok_pkg::KIND_ASSIGN;
                                default: pk = c_tok_pkg::KIND_INVALID;
                            endcase
                            emit(pk, '0, 8'h00, 1'b1);
                            // an invalid char stops the lexer until reset
                            if (pk == c_tok_pkg::KIND_INVALID)
                                lex_mode = c_tok_pkg::MODE_DEAD;
                        end
                    end
                endcase
            end
        end
    endfunction

    // stimulus helpers
    task automatic add_beat(input logic eoi, input logic [7:0] c, input bit drain);
        src_beat_t b;
        if ($urandom_range(0, 19) == 0)
            tx_steady = !tx_steady;
        b.eoi   = eoi;
        b.ch    = c;
        b.drain = drain;
        b.gap   = tx_steady ? 0 : $urandom_range(0, 5);
        src_beats.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_beat(1'b0, s[i], 1'b0);
    endtask

    task automatic add_eof(input bit drain);
        add_beat(1'b1, 8'($urandom_range(0, 255)), drain);
    endtask

    function automatic logic [7:0] rand_alpha();
        logic [7:0] c;
        case ($urandom_range(0, 4))
            0:       c = "_";
            1, 2:    c = "a" + 8'($urandom_range(0, 25));
            default: c = "A" + 8'($urandom_range(0, 25));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    // stimulus build, reset and end of run
    initial
    begin
        string      kw_pool [12];
        string      punct_set;
        logic [7:0] blank_set [6];
        int         pick;
        int         len;

        kw_pool   = '{"int", "char", "if", "else", "while", "return",
                      "in", "ifx", "Int", "els", "returns", "whil"};
        punct_set = "(){}[];:,.+-*/=";
        blank_set = '{8'h20, 8'h09, 8'h0b, 8'h0d, 8'h0c, 8'h0a};

        // directed: a keyword, a name that starts with a keyword, literal wrap, newline, eof with pause
        add_text("if else1 Z_z 4294967297\n");
        add_eof(1'b1);

        // random token streams with some noise
        while (src_beats.size() < 295)
        begin
            if ($urandom_range(0, 39) == 0)
                add_beat(1'b0, 8'h20, 1'b1);
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 40)
                                                  : $urandom_range(1, 8);
                add_beat(1'b0, rand_alpha(), 1'b0);
                for (int i = 1; i < len; i++)
                    add_beat(1'b0, ($urandom_range(0, 2) == 0) ? rand_digit()
                                                               : rand_alpha(), 1'b0);
            end
            else if (pick < 40)
            begin
                add_text(kw_pool[$urandom_range(0, 11)]);
            end
            else if (pick < 55)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14)
                                                  : $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    add_beat(1'b0, rand_digit(), 1'b0);
            end
            else if (pick < 80)
            begin
                add_beat(1'b0, punct_set[$urandom_range(0, 14)], 1'b0);
            end
            else if (pick < 88)
            begin
                repeat ($urandom_range(1, 3))
                    add_beat(1'b0, blank_set[$urandom_range(0, 5)], 1'b0);
            end
            else if (pick < 95)
            begin
                case ($urandom_range(0, 3))
                    0:       add_beat(1'b0, rand_alpha(), 1'b0);
                    1:       add_beat(1'b0, rand_digit(), 1'b0);
                    2:       add_beat(1'b0, punct_set[$urandom_range(0, 14)], 1'b0);
                    default: add_beat(1'b0, blank_set[$urandom_range(0, 5)], 1'b0);
                endcase
            end
            else
            begin
                add_eof(1'b0);
            end
            // separator or none, adjacent tokens may merge
            if ($urandom_range(0, 1) == 0)
                add_beat(1'b0, blank_set[$urandom_range(0, 5)], 1'b0);
        end

        // a few more lines, then end of input
        add_text("x1\n");
        add_text("abc=42;\n");
        add_eof(1'b0);

        // invalid char after a pending name, then everything is ignored
        add_beat(1'b0, "q", 1'b1);
        add_text("=9 (ab");
        add_beat(1'b0, 8'hff, 1'b0);
        add_text("z1");
        add_eof(1'b0);
        repeat (4)
            add_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0);
        add_eof(1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (src_beats.size() != 0 || push)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // driver: one source beat per handshake, gaps and drain pauses from the queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            cmd      <= 1'b0;
            char_in  <= 8'h00;
            gap_left <= 0;
        end
        else
        begin
            go = 1'b0;
            if (push && !full)
            begin
                lex_step(cmd, char_in);
                go = 1'b1;
            end
            else if (!push)
            begin
                go = 1'b1;
            end
            if (go)
            begin
                if (src_beats.size() != 0 && gap_left >= src_beats[0].gap &&
                    (!src_beats[0].drain || expected_tokens.size() == 0))
                begin
                    nxt = src_beats.pop_front();
                    push     <= 1'b1;
                    cmd      <= nxt.eoi;
                    char_in  <= nxt.ch;
                    gap_left <= 0;
                end
                else
                begin
                    push <= 1'b0;
                    if (src_beats.size() != 0 && gap_left < src_beats[0].gap)
                        gap_left <= gap_left + 1;
                end
            end
        end
    end

    // monitor: check each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_wait <= 0;
        end
        else if (pop && !empty)
        begin
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected result beat: kind %0d", kind);
                fail_count++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    fail_count++;
                end
                if (number !== want.number)
                begin
                    $error("number: expected %0d, got %0d", want.number, number);
                    fail_count++;
                end
                if (text_char !== want.text_char)
                begin
                    $error("text_char: expected %0d, got %0d", want.text_char, text_char);
                    fail_count++;
                end
                if (line_no !== want.line_no)
                begin
                    $error("line_no: expected %0d, got %0d", want.line_no, line_no);
                    fail_count++;
                end
                if (last !== want.is_last)
                begin
                    $error("last: expected %0d, got %0d", want.is_last, last);
                    fail_count++;
                end
            end
            // stall before the next beat, with stretches of none
            if ($urandom_range(0, 23) == 0)
                rx_steady = !rx_steady;
            rx_draw = rx_steady ? 0 : $urandom_range(0, 5);
            pop_wait <= rx_draw;
            pop      <= (rx_draw == 0);
        end
        else if (!pop)
        begin
            if (pop_wait <= 1)
            begin
                pop      <= 1'b1;
                pop_wait <= 0;
            end
            else
            begin
                pop_wait <= pop_wait - 1;
            end
        end
    end

endmodule
